FILE: rtl/lsb_pkg.sv
// Shared types, constants and the blink pattern table for the LED blink controller.
`timescale 1ns / 1ps
`default_nettype none
package lsb_pkg;

	localparam int PATTERN_COUNT_DEF = 5;
	localparam logic [2:0] PAT_TABLE_SIZE = 3'd5;

	// Register reset values
	localparam logic [7:0]  ACT_TICK_MS_RST    = 8'd50;
	localparam logic [3:0]  ACT_PULSE_RST      = 4'd2;
	localparam logic [15:0] STOP_HOLDOFF_RST   = 16'd1000;
	localparam logic [10:0] INIT_ON_MS         = 11'd100;

	localparam int APB_ADDR_W = 4;

	typedef enum logic [1:0] {
		REG_ACT_TICK_MS  = 2'd0,
		REG_ACT_PULSE    = 2'd1,
		REG_STOP_HOLDOFF = 2'd2
	} lsb_reg_t;

	typedef enum logic [2:0] {
		ACT_MS_TICK    = 3'd0,
		ACT_CAN_ACT    = 3'd1,
		ACT_CH_START   = 3'd2,
		ACT_CH_STOP    = 3'd3,
		ACT_SET_STATUS = 3'd4,
		ACT_SET_STATIC = 3'd5
	} lsb_action_t;

	localparam logic [2:0] PAT_IDLE  = 3'd1;
	localparam logic [2:0] PAT_READY = 3'd2;

	typedef struct packed {
		logic [2:0] action;
		logic [2:0] status_code;
		logic       static_on;
	} lsb_item_t;

	typedef struct packed {
		logic [7:0]  act_tick_ms;
		logic [3:0]  act_pulse_ticks;
		logic [15:0] stop_holdoff_ms;
	} lsb_cfg_t;

	typedef struct packed {
		logic [10:0] on_ms;
		logic [10:0] off_ms;
		logic [6:0]  repeats;   // zero = endless
	} lsb_pat_t;

	function automatic lsb_pat_t lsb_pattern(input logic [2:0] idx);
		lsb_pat_t p;
		case (idx)
			3'd1:    p = '{on_ms: 11'd100, off_ms: 11'd1900, repeats: 7'd0};
			3'd2:    p = '{on_ms: 11'd500, off_ms: 11'd500,  repeats: 7'd0};
			3'd3:    p = '{on_ms: 11'd50,  off_ms: 11'd50,   repeats: 7'd1};
			3'd4:    p = '{on_ms: 11'd100, off_ms: 11'd100,  repeats: 7'd0};
			default: p = '{on_ms: 11'd100, off_ms: 11'd100,  repeats: 7'd3};
		endcase
		return p;
	endfunction

endpackage
`default_nettype wire

FILE: rtl/led_status_blink_controller_top.sv
// LED blink controller: input register, status and activity units, result register.
// A result is registered in the result register when its item leaves the input register.
// Throughput: one item per cycle; the input register refills while the result
// register is taken, and ready drops only when both are full and the sink stalls.
// Reset (arst_n low, asynchronous): init pattern running with status level on, activity
// level off, hold-offs expired, registers at 50 ms / 2 ticks / 1000 ms; LED outputs not reset.
`timescale 1ns / 1ps
`default_nettype none
module led_status_blink_controller_top #(
	parameter int PATTERN_COUNT = lsb_pkg::PATTERN_COUNT_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          item_valid,
	output logic                               item_ready,
	input  wire logic [2:0]                    action,
	input  wire logic [2:0]                    status_code,
	input  wire logic                          static_on,
	output logic                               result_valid,
	input  wire logic                          result_ready,
	output logic                               status_led_on,
	output logic                               activity_led_on,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [lsb_pkg::APB_ADDR_W-1:0] paddr,
	input  wire logic [31:0]                   pwdata,
	output logic [31:0]                        prdata,
	output logic                               pready
);
	import lsb_pkg::*;

	lsb_cfg_t   cfg_q;
	lsb_item_t  item_s1;
	logic       valid_s1;
	logic       advance;
	logic       apply;
	logic       status_nxt;
	logic       activity_nxt;
	logic       cfg_wr;
	logic [1:0] reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];
	assign cfg_wr  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.act_tick_ms     <= ACT_TICK_MS_RST;
			cfg_q.act_pulse_ticks <= ACT_PULSE_RST;
			cfg_q.stop_holdoff_ms <= STOP_HOLDOFF_RST;
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_ACT_TICK_MS:  cfg_q.act_tick_ms     <= pwdata[7:0];
				REG_ACT_PULSE:    cfg_q.act_pulse_ticks <= pwdata[3:0];
				REG_STOP_HOLDOFF: cfg_q.stop_holdoff_ms <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_ACT_TICK_MS:  prdata = {24'd0, cfg_q.act_tick_ms};
			REG_ACT_PULSE:    prdata = {28'd0, cfg_q.act_pulse_ticks};
			REG_STOP_HOLDOFF: prdata = {16'd0, cfg_q.stop_holdoff_ms};
			default:          prdata = 32'd0;
		endcase
	end

	// stage 1 drains whenever the result register is free or being taken
	assign advance    = !result_valid || result_ready;
	assign apply      = valid_s1 && advance;
	assign item_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (item_ready)
			valid_s1 <= item_valid;
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			item_s1.action      <= action;
			item_s1.status_code <= status_code;
			item_s1.static_on   <= static_on;
		end
	end

	lsb_status #(
		.PATTERN_COUNT(PATTERN_COUNT)
	) u_status (
		.clk             (clk),
		.arst_n          (arst_n),
		.apply           (apply),
		.item            (item_s1),
		.stop_holdoff_ms (cfg_q.stop_holdoff_ms),
		.level_next      (status_nxt)
	);

	lsb_activity u_activity (
		.clk        (clk),
		.arst_n     (arst_n),
		.apply      (apply),
		.item       (item_s1),
		.cfg        (cfg_q),
		.level_next (activity_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			result_valid <= 1'b0;
		else if (apply)
			result_valid <= 1'b1;
		else if (result_ready)
			result_valid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (apply) begin
			status_led_on   <= status_nxt;
			activity_led_on <= activity_nxt;
		end
	end

endmodule
`default_nettype wire

FILE: rtl/lsb_status.sv
// Status LED pattern sequencer with stop-event hold-off.
`timescale 1ns / 1ps
`default_nettype none
module lsb_status #(
	parameter int PATTERN_COUNT = lsb_pkg::PATTERN_COUNT_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              apply,
	input  wire lsb_pkg::lsb_item_t item,
	input  wire logic [15:0]       stop_holdoff_ms,
	output logic                   level_next
);
	import lsb_pkg::*;

	logic [2:0]  sel_q,     sel_n;
	logic        on_q,      on_n;
	logic [10:0] timer_q,   timer_n;
	logic [6:0]  rd_q,      rd_n;
	logic        run_q,     run_n;
	logic        level_q,   level_n;
	logic [15:0] hold_q,    hold_n;

	logic [6:0]  rd_inc;
	lsb_pat_t    cur_pat;
	lsb_pat_t    new_pat;
	logic [2:0]  new_code;
	logic        do_select;

	assign rd_inc  = rd_q + 7'd1;
	assign cur_pat = lsb_pattern((sel_q >= PAT_TABLE_SIZE) ? 3'd0 : sel_q);

	always_comb begin
		sel_n     = sel_q;
		on_n      = on_q;
		timer_n   = timer_q;
		rd_n      = rd_q;
		run_n     = run_q;
		level_n   = level_q;
		hold_n    = hold_q;
		new_code  = item.status_code;
		do_select = 1'b0;

		case (item.action)
			ACT_MS_TICK: begin
				if (hold_q != 16'd0)
					hold_n = hold_q - 16'd1;
				if (run_q) begin
					if (timer_q > 11'd1) begin
						timer_n = timer_q - 11'd1;
					end else if (on_q) begin
						level_n = 1'b0;
						on_n    = 1'b0;
						timer_n = cur_pat.off_ms;
						if (cur_pat.repeats != 7'd0) begin
							rd_n = rd_inc;
							if (rd_inc >= cur_pat.repeats) begin
								run_n   = 1'b0;
								timer_n = 11'd0;
							end
						end
					end else begin
						level_n = 1'b1;
						on_n    = 1'b1;
						timer_n = cur_pat.on_ms;
					end
				end
			end
			ACT_CH_START: begin
				hold_n    = 16'd0;
				new_code  = PAT_READY;
				do_select = 1'b1;
			end
			ACT_CH_STOP: begin
				if (hold_q == 16'd0) begin
					hold_n    = stop_holdoff_ms;
					new_code  = PAT_IDLE;
					do_select = 1'b1;
				end
			end
			ACT_SET_STATUS: begin
				do_select = 1'b1;
			end
			ACT_SET_STATIC: begin
				run_n   = 1'b0;
				level_n = item.static_on;
			end
			default: ;
		endcase

		new_pat = lsb_pattern(new_code);
		// codes past the configured count or the table are ignored
		if (do_select && (int'(new_code) < PATTERN_COUNT) && (new_code < PAT_TABLE_SIZE)) begin
			sel_n   = new_code;
			on_n    = 1'b1;
			timer_n = new_pat.on_ms;
			rd_n    = 7'd0;
			run_n   = 1'b1;
			level_n = 1'b1;
		end
	end

	assign level_next = level_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sel_q   <= 3'd0;
			on_q    <= 1'b1;
			timer_q <= INIT_ON_MS;
			rd_q    <= 7'd0;
			run_q   <= 1'b1;
			level_q <= 1'b1;
			hold_q  <= 16'd0;
		end else if (apply) begin
			sel_q   <= sel_n;
			on_q    <= on_n;
			timer_q <= timer_n;
			rd_q    <= rd_n;
			run_q   <= run_n;
			level_q <= level_n;
			hold_q  <= hold_n;
		end
	end

endmodule
`default_nettype wire

FILE: rtl/lsb_activity.sv
// Activity LED pulse generator with tick prescaler and event hold-off.
`timescale 1ns / 1ps
`default_nettype none
module lsb_activity (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               apply,
	input  wire lsb_pkg::lsb_item_t item,
	input  wire lsb_pkg::lsb_cfg_t  cfg,
	output logic                    level_next
);
	import lsb_pkg::*;

	logic [7:0]  presc_q, presc_n;
	logic [3:0]  left_q,  left_n;
	logic        level_q, level_n;
	logic [11:0] hold_q,  hold_n;

	logic [7:0]  period;
	logic [8:0]  presc_inc;
	logic [3:0]  left_dec;
	logic [11:0] pulse_len;

	assign period    = (cfg.act_tick_ms == 8'd0) ? 8'd1 : cfg.act_tick_ms;
	assign presc_inc = {1'b0, presc_q} + 9'd1;
	assign left_dec  = left_q - 4'd1;
	assign pulse_len = {4'd0, cfg.act_tick_ms} * {8'd0, cfg.act_pulse_ticks};

	always_comb begin
		presc_n = presc_q;
		left_n  = left_q;
		level_n = level_q;
		hold_n  = hold_q;
		case (item.action)
			ACT_MS_TICK: begin
				if (hold_q != 12'd0)
					hold_n = hold_q - 12'd1;
				if (presc_inc >= {1'b0, period}) begin
					presc_n = 8'd0;
					if (left_q != 4'd0) begin
						left_n = left_dec;
						// zero wins over the half-way mark
						if (left_dec == 4'd0)
							level_n = 1'b0;
						else if (left_dec == {1'b0, cfg.act_pulse_ticks[3:1]})
							level_n = 1'b1;
					end
				end else begin
					presc_n = presc_inc[7:0];
				end
			end
			ACT_CAN_ACT: begin
				if (hold_q == 12'd0) begin
					hold_n = pulse_len;
					left_n = cfg.act_pulse_ticks;
				end
			end
			default: ;
		endcase
	end

	assign level_next = level_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			presc_q <= 8'd0;
			left_q  <= 4'd0;
			level_q <= 1'b0;
			hold_q  <= 12'd0;
		end else if (apply) begin
			presc_q <= presc_n;
			left_q  <= left_n;
			level_q <= level_n;
			hold_q  <= hold_n;
		end
	end

endmodule
`default_nettype wire
